// ===== rtl/olpe_pkg.sv =====
// Package for the ordered list position engine: request and response words,
// function and status codes, and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package olpe_pkg;

   localparam int CAPACITY_DEF = 64;

   // Request function codes
   localparam logic [2:0] FUNC_INS_FRONT = 3'd0;
   localparam logic [2:0] FUNC_INS_END   = 3'd1;
   localparam logic [2:0] FUNC_INS_POS   = 3'd2;
   localparam logic [2:0] FUNC_DEL_FRONT = 3'd3;
   localparam logic [2:0] FUNC_DEL_END   = 3'd4;
   localparam logic [2:0] FUNC_DEL_POS   = 3'd5;
   localparam logic [2:0] FUNC_SEARCH    = 3'd6;
   localparam logic [2:0] FUNC_COUNT     = 3'd7;

   // Response status codes
   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_EMPTY    = 3'd1;
   localparam logic [2:0] STATUS_BADPOS   = 3'd2;
   localparam logic [2:0] STATUS_OOB      = 3'd3;
   localparam logic [2:0] STATUS_NOTFOUND = 3'd4;
   localparam logic [2:0] STATUS_FULL     = 3'd5;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] value;
      logic [6:0]         position;
   } req_word_type;

   typedef struct packed {
      logic [2:0] status;
      logic [6:0] found_position;
      logic [6:0] element_count;
   } rsp_word_type;

   // Controller -> datapath
   typedef struct packed {
      logic       load;
      logic       start_up;
      logic       start_dn;
      logic       start_scan;
      logic       step_up;
      logic       step_dn;
      logic       step_scan;
      logic       put;
      logic       take;
      logic       hit;
      logic       set_status;
      logic [2:0] status_code;
   } cmd_type;

   // Datapath -> controller
   typedef struct packed {
      logic [2:0] func;
      logic       len_zero;
      logic       len_full;
      logic       pos_zero;
      logic       pos_gt_len;
      logic       pos_gt_len1;
      logic       up_done;
      logic       dn_done;
      logic       hit;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/olpe_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module olpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/olpe_ctrl.sv =====
// Controller state machine for the ordered list position engine.
// Depends on olpe_pkg (command and status structs, codes).
`timescale 1ns / 1ps
`default_nettype none

module olpe_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   output logic                        rsp_valid,
   output olpe_pkg::cmd_type           cmd,
   input  wire olpe_pkg::dp_status_type st
);

   import olpe_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_UP     = 3'd2;
   localparam logic [2:0] S_DN     = 3'd3;
   localparam logic [2:0] S_SRCH   = 3'd4;
   localparam logic [2:0] S_RESP   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.set_status  = 1'b1;
            cmd.status_code = STATUS_OK;
            state_in        = S_RESP;
            case (st.func)
               FUNC_INS_FRONT, FUNC_INS_END: begin
                  if (st.len_full) begin
                     cmd.status_code = STATUS_FULL;
                  end else begin
                     cmd.start_up = 1'b1;
                     state_in     = S_UP;
                  end
               end
               FUNC_INS_POS: begin
                  if (st.pos_zero) begin
                     cmd.status_code = STATUS_BADPOS;
                  end else if (st.pos_gt_len1) begin
                     cmd.status_code = STATUS_OOB;
                  end else if (st.len_full) begin
                     cmd.status_code = STATUS_FULL;
                  end else begin
                     cmd.start_up = 1'b1;
                     state_in     = S_UP;
                  end
               end
               FUNC_DEL_FRONT, FUNC_DEL_END: begin
                  if (st.len_zero) begin
                     cmd.status_code = STATUS_EMPTY;
                  end else begin
                     cmd.start_dn = 1'b1;
                     state_in     = S_DN;
                  end
               end
               FUNC_DEL_POS: begin
                  if (st.len_zero) begin
                     cmd.status_code = STATUS_EMPTY;
                  end else if (st.pos_zero) begin
                     cmd.status_code = STATUS_BADPOS;
                  end else if (st.pos_gt_len) begin
                     cmd.status_code = STATUS_OOB;
                  end else begin
                     cmd.start_dn = 1'b1;
                     state_in     = S_DN;
                  end
               end
               FUNC_SEARCH: begin
                  if (st.len_zero) begin
                     cmd.status_code = STATUS_EMPTY;
                  end else begin
                     // assume a miss until the scan proves otherwise
                     cmd.status_code = STATUS_NOTFOUND;
                     cmd.start_scan  = 1'b1;
                     state_in        = S_SRCH;
                  end
               end
               default: begin
                  cmd.status_code = STATUS_OK;
               end
            endcase
         end
         S_UP: begin
            if (st.up_done) begin
               cmd.put  = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.step_up = 1'b1;
            end
         end
         S_DN: begin
            if (st.dn_done) begin
               cmd.take = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.step_dn = 1'b1;
            end
         end
         S_SRCH: begin
            if (st.hit) begin
               cmd.hit         = 1'b1;
               cmd.set_status  = 1'b1;
               cmd.status_code = STATUS_OK;
               state_in        = S_RESP;
            end else if (st.dn_done) begin
               state_in = S_RESP;
            end else begin
               cmd.step_scan = 1'b1;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/olpe_datapath.sv =====
// Datapath for the ordered list position engine: element store, length,
// walk pointer with one-deep read pipeline, compare and response registers.
// Depends on olpe_pkg and olpe_ram.
`timescale 1ns / 1ps
`default_nettype none

module olpe_datapath #(
   parameter int CAPACITY = olpe_pkg::CAPACITY_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire olpe_pkg::req_word_type req_data,
   input  wire olpe_pkg::cmd_type      cmd,
   output olpe_pkg::dp_status_type     st,
   output olpe_pkg::rsp_word_type      rsp_data
);

   import olpe_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int PW = $clog2(CAPACITY + 1);
   localparam int CW = ((PW > 7) ? PW : 7) + 1;

   req_word_type  req_ff;
   logic [PW-1:0] len_ff, len_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [PW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic [AW-1:0] pend_addr_ff, pend_addr_in;
   logic [2:0]    status_ff;
   logic [6:0]    found_ff;

   logic [PW-1:0] ptr_dec;
   logic [PW-1:0] len_dec;
   logic [PW-1:0] target;
   logic [PW-1:0] pend_pos;
   logic [CW-1:0] pos_w;
   logic [CW-1:0] len_w;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_data;

   assign ptr_dec  = ptr_ff - 1'b1;
   assign len_dec  = len_ff - 1'b1;
   assign pend_pos = PW'(pend_addr_ff) + 1'b1;
   assign pos_w    = CW'(req_ff.position);
   assign len_w    = CW'(len_ff);

   // 0-based entry touched by the current insert or delete
   always_comb begin
      case (req_ff.func)
         FUNC_INS_FRONT, FUNC_DEL_FRONT: target = '0;
         FUNC_INS_END:                   target = len_ff;
         FUNC_DEL_END:                   target = len_dec;
         default:                        target = PW'(pos_w - 1'b1);
      endcase
   end

   always_comb begin
      st.func        = req_ff.func;
      st.len_zero    = (len_ff == '0);
      st.len_full    = (len_ff == PW'(CAPACITY));
      st.pos_zero    = (req_ff.position == '0);
      st.pos_gt_len  = (pos_w > len_w);
      st.pos_gt_len1 = (pos_w > (len_w + 1'b1));
      st.up_done     = (ptr_ff == idx_ff) && !pend_ff;
      st.dn_done     = (ptr_ff >= len_ff) && !pend_ff;
      st.hit         = pend_ff && (rd_data == $unsigned(req_ff.value));
   end

   // Walk control: up moves entries toward the tail, dn and scan read toward it
   always_comb begin
      ptr_in       = ptr_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      len_in       = len_ff;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff[AW-1:0];

      if (cmd.start_up) begin
         ptr_in  = len_ff;
         idx_in  = target;
         pend_in = 1'b0;
      end
      if (cmd.start_dn) begin
         ptr_in  = target + 1'b1;
         idx_in  = target;
         pend_in = 1'b0;
      end
      if (cmd.start_scan) begin
         ptr_in  = '0;
         pend_in = 1'b0;
      end
      if (cmd.step_up) begin
         if (ptr_ff > idx_ff) begin
            rd_en        = 1'b1;
            rd_addr      = ptr_dec[AW-1:0];
            pend_in      = 1'b1;
            pend_addr_in = ptr_ff[AW-1:0];
            ptr_in       = ptr_dec;
         end else begin
            pend_in = 1'b0;
         end
      end
      if (cmd.step_dn || cmd.step_scan) begin
         if (ptr_ff < len_ff) begin
            rd_en        = 1'b1;
            rd_addr      = ptr_ff[AW-1:0];
            pend_in      = 1'b1;
            pend_addr_in = cmd.step_dn ? ptr_dec[AW-1:0] : ptr_ff[AW-1:0];
            ptr_in       = ptr_ff + 1'b1;
         end else begin
            pend_in = 1'b0;
         end
      end
      if (cmd.put) begin
         len_in = len_ff + 1'b1;
      end
      if (cmd.take) begin
         len_in = len_dec;
      end
   end

   // Write back the moved word, or the new word on put
   assign wr_en   = cmd.put || ((cmd.step_up || cmd.step_dn) && pend_ff);
   assign wr_addr = cmd.put ? idx_ff[AW-1:0] : pend_addr_ff;
   assign wr_data = cmd.put ? $unsigned(req_ff.value) : rd_data;

   olpe_ram #(
      .WIDTH (32),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         len_ff  <= len_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      idx_ff       <= idx_in;
      pend_addr_ff <= pend_addr_in;
      if (cmd.load) begin
         req_ff   <= req_data;
         found_ff <= '0;
      end
      if (cmd.hit) begin
         found_ff <= 7'(pend_pos);
      end
      if (cmd.set_status) begin
         status_ff <= cmd.status_code;
      end
   end

   always_comb begin
      rsp_data.status         = status_ff;
      rsp_data.found_position = found_ff;
      rsp_data.element_count  = 7'(len_ff);
   end

endmodule

`default_nettype wire

// ===== rtl/ordered_list_position_engine_unit.sv =====
// Ordered list position engine, top level: controller plus datapath.
// Depends on olpe_pkg, olpe_ctrl, olpe_datapath (and through it olpe_ram).
//
// Usage
//   Request channel: drive req_data (func, value, position) and raise start;
//   the word is taken at the rising edge where start is high and busy low.
//   busy then stays high until the response has been shown.
//   Response channel: rsp_valid pulses for exactly one cycle with rsp_data
//   (status, found_position, element_count). The receiver has no way to
//   stall it; it must take the word in that cycle.
//   Count and every rejected request go from decode straight to the response.
//   An insert at 0-based entry i first moves the entries from the tail down
//   to entry i one place toward the tail, then writes the new word at i; a
//   delete moves the entries above i one place toward the front, then
//   shortens the list. A search reads from entry 0 until the first match or
//   the end of the list. Entries are moved or scanned one at a time through
//   the store's single read/write port pair.
//   A new request is accepted the cycle after the strobe.
//   Reset (synchronous, active high) empties the list and returns to idle;
//   store contents are not cleared, only entries below the length are read.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_position_engine_unit #(
   parameter int CAPACITY = olpe_pkg::CAPACITY_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire olpe_pkg::req_word_type req_data,
   output logic                        rsp_valid,
   output olpe_pkg::rsp_word_type      rsp_data
);

   import olpe_pkg::*;

   cmd_type       cmd;
   dp_status_type dp_st;

   // Sequence each request: decode, walk the store, then strobe the result
   olpe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .st        (dp_st)
   );

   // Hold the list, shift entries and build the response word
   olpe_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .st       (dp_st),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/olpe_checker.sv =====
// Port-level checker for the ordered list position engine, bound to the top level.
// Depends on olpe_pkg and ordered_list_position_engine_unit.
`timescale 1ns / 1ps
`default_nettype none

module olpe_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic                   rsp_valid,
   input wire olpe_pkg::rsp_word_type rsp_data
);

   import olpe_pkg::*;

   // An accepted word makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // The response strobe lasts one cycle and falls with busy
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("response strobe not a single cycle ending the request");

   // A response only comes while a request is outstanding
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response strobe while idle");

   // A found position only comes with a successful status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found_position != 7'd0) |-> (rsp_data.status == STATUS_OK))
      else $error("found position with a failing status");

   // Status codes stay within the defined set
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= STATUS_FULL))
      else $error("undefined status code");

endmodule

bind ordered_list_position_engine_unit olpe_checker u_olpe_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for ordered_list_position_engine_unit: directed and random
// list requests, with every response checked against a shadow copy of the list.
// Depends on olpe_pkg and the RTL of the unit; reads no files.
`timescale 1ns / 1ps

module testbench;
   import olpe_pkg::*;

   localparam int SLOTS       = CAPACITY_DEF;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = SLOTS + 16;

   typedef enum {TREND_GROW, TREND_SHRINK, TREND_MIXED} trend_type;

   // Shadow of the list: predicts one response word per request word and
   // holds the responses still owed by the unit.
   class list_tracker_type;
      logic [31:0]  words [SLOTS];
      int unsigned  length;
      rsp_word_type owed [$];
      int unsigned  mismatches;
      int unsigned  checked;
      int unsigned  full_rejects;
      int unsigned  search_hits;
      int unsigned  peak;

      function new();
         length       = 0;
         mismatches   = 0;
         checked      = 0;
         full_rejects = 0;
         search_hits  = 0;
         peak         = 0;
      endfunction

      function void place(int unsigned idx, logic [31:0] w);
         for (int unsigned k = length; k > idx; k--) words[k] = words[k - 1];
         words[idx] = w;
         length++;
      endfunction

      function void drop(int unsigned idx);
         for (int unsigned k = idx; k + 1 < length; k++) words[k] = words[k + 1];
         length--;
      endfunction

      function void note_request(req_word_type r);
         rsp_word_type want;
         want = '0;
         want.status = STATUS_OK;
         case (r.func)
            FUNC_INS_FRONT, FUNC_INS_END: begin
               if (length >= SLOTS) want.status = STATUS_FULL;
               else place((r.func == FUNC_INS_FRONT) ? 0 : length, r.value);
            end
            FUNC_INS_POS: begin
               // bad and out-of-range positions win over a full list
               if (r.position == 0) want.status = STATUS_BADPOS;
               else if (r.position > length + 1) want.status = STATUS_OOB;
               else if (length >= SLOTS) want.status = STATUS_FULL;
               else place(r.position - 1, r.value);
            end
            FUNC_DEL_FRONT, FUNC_DEL_END: begin
               if (length == 0) want.status = STATUS_EMPTY;
               else drop((r.func == FUNC_DEL_FRONT) ? 0 : length - 1);
            end
            FUNC_DEL_POS: begin
               if (length == 0) want.status = STATUS_EMPTY;
               else if (r.position == 0) want.status = STATUS_BADPOS;
               else if (r.position > length) want.status = STATUS_OOB;
               else drop(r.position - 1);
            end
            FUNC_SEARCH: begin
               if (length == 0) begin
                  want.status = STATUS_EMPTY;
               end else begin
                  want.status = STATUS_NOTFOUND;
                  for (int unsigned k = 0; k < length; k++) begin
                     if (words[k] == r.value) begin
                        want.status         = STATUS_OK;
                        want.found_position = 7'(k + 1);
                        break;
                     end
                  end
               end
            end
            default: ;
         endcase
         want.element_count = 7'(length);
         if (want.status == STATUS_FULL) full_rejects++;
         if (r.func == FUNC_SEARCH && want.status == STATUS_OK) search_hits++;
         if (length > peak) peak = length;
         owed.push_back(want);
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type want;
         if (owed.size() == 0) begin
            $error("response word with no request outstanding");
            mismatches++;
            return;
         end
         want = owed.pop_front();
         checked++;
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
         end
         if (got.found_position !== want.found_position) begin
            $error("found_position: expected %0d, got %0d",
                   want.found_position, got.found_position);
            mismatches++;
         end
         if (got.element_count !== want.element_count) begin
            $error("element_count: expected %0d, got %0d",
                   want.element_count, got.element_count);
            mismatches++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   req_word_type req_data;
   logic         rsp_valid;
   rsp_word_type rsp_data;

   list_tracker_type board;
   int unsigned      issued = 0;
   int unsigned      cycle_count = 0;

   ordered_list_position_engine_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Check every response word in the cycle it is shown.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1) board.check_response(rsp_data);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $error("timeout after %0d cycles, %0d responses owed", cycle_count,
                board.owed.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // Present one word and hold it until the unit takes it; leave start high
   // so that a following word goes out back to back.
   task automatic send_word(input req_word_type w);
      req_data <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_request(w);
      issued++;
   endtask

   task automatic issue(input logic [2:0] f, input logic [31:0] v, input int unsigned p);
      req_word_type w;
      w.func     = f;
      w.value    = v;
      w.position = 7'(p);
      send_word(w);
   endtask

   // Idle the sender with the given chance per cycle.
   task automatic idle_sender(input int unsigned pct);
      if (pct != 0 && $urandom_range(99) < pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < pct);
      end
   endtask

   // Hold off until every owed response has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.owed.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(9))
         0: begin
            case ($urandom_range(3))
               0:       return 32'h8000_0000;
               1:       return 32'h7fff_ffff;
               2:       return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         // small pool: duplicates make search report the first match
         1, 2, 3: return 32'($urandom_range(7));
         default: return $urandom;
      endcase
   endfunction

   // Mostly a legal position in 1..top, sometimes zero, one past, or anything.
   function automatic logic [6:0] aim_position(input int unsigned top);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 80 && top != 0) return 7'($urandom_range(1, top));
      if (roll < 86) return 7'd0;
      if (roll < 93) return 7'(top + 1);
      return 7'($urandom_range(127));
   endfunction

   function automatic req_word_type next_request(input trend_type trend);
      req_word_type r;
      int unsigned  len;
      int unsigned  roll;
      int unsigned  ins_pct;
      int unsigned  del_pct;
      len        = board.length;
      r.value    = pick_word();
      r.position = 7'($urandom_range(127));
      case (trend)
         TREND_GROW: begin
            ins_pct = 70;
            del_pct = 12;
         end
         TREND_SHRINK: begin
            ins_pct = 15;
            del_pct = 65;
         end
         default: begin
            ins_pct = 40;
            del_pct = 35;
         end
      endcase
      // noise: any function with arbitrary fields
      if ($urandom_range(99) < 6) begin
         r.func = 3'($urandom_range(7));
         return r;
      end
      roll = $urandom_range(99);
      if (roll < ins_pct) begin
         case ($urandom_range(2))
            0:       r.func = FUNC_INS_FRONT;
            1:       r.func = FUNC_INS_END;
            default: begin
               r.func     = FUNC_INS_POS;
               r.position = aim_position(len + 1);
            end
         endcase
      end else if (roll < ins_pct + del_pct) begin
         case ($urandom_range(2))
            0:       r.func = FUNC_DEL_FRONT;
            1:       r.func = FUNC_DEL_END;
            default: begin
               r.func     = FUNC_DEL_POS;
               r.position = aim_position(len);
            end
         endcase
      end else if (roll < 95) begin
         r.func = FUNC_SEARCH;
         if (len != 0 && $urandom_range(9) < 6) r.value = board.words[$urandom_range(len - 1)];
      end else begin
         r.func = FUNC_COUNT;
      end
      return r;
   endfunction

   initial begin
      int unsigned sent;
      int unsigned burst;
      int unsigned idle_pct;
      trend_type   trend;
      board = new();
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty-list cases, field extremes, every function.
      issue(FUNC_COUNT,     32'd0,         0);
      issue(FUNC_DEL_FRONT, 32'd0,         0);
      issue(FUNC_DEL_END,   32'd0,         0);
      issue(FUNC_DEL_POS,   32'd0,         0);
      issue(FUNC_SEARCH,    32'd5,         0);
      issue(FUNC_INS_POS,   32'd1,         0);
      issue(FUNC_INS_POS,   32'd1,         2);
      issue(FUNC_INS_POS,   32'd1,         127);
      issue(FUNC_INS_POS,   32'h8000_0000, 1);
      issue(FUNC_INS_FRONT, 32'h7fff_ffff, 127);
      issue(FUNC_INS_END,   32'h0000_0000, 0);
      issue(FUNC_INS_END,   32'hffff_ffff, 0);
      issue(FUNC_SEARCH,    32'hffff_ffff, 0);
      issue(FUNC_SEARCH,    32'd12345,     0);
      issue(FUNC_DEL_POS,   32'd0,         0);
      issue(FUNC_DEL_POS,   32'd0,         5);
      issue(FUNC_INS_POS,   32'd77,        5);
      issue(FUNC_INS_POS,   32'hffff_ffff, 3);
      issue(FUNC_SEARCH,    32'hffff_ffff, 0);
      issue(FUNC_DEL_POS,   32'd0,         3);
      issue(FUNC_DEL_FRONT, 32'd0,         0);
      issue(FUNC_DEL_END,   32'd0,         0);
      issue(FUNC_DEL_POS,   32'd0,         3);
      issue(FUNC_COUNT,     32'hffff_ffff, 127);
      drain();

      // Random: sender idles rarely, then often, then never; bursts that
      // grow the list, shrink it, or mix.
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       idle_pct = 7;
            1:       idle_pct = 82;
            default: idle_pct = 0;
         endcase
         sent = 0;
         while (sent < 560) begin
            trend = trend_type'($urandom_range(2));
            burst = $urandom_range(20, 160);
            if (burst > 560 - sent) burst = 560 - sent;
            repeat (burst) begin
               send_word(next_request(trend));
               sent++;
               idle_sender(idle_pct);
            end
            if ($urandom_range(9) == 0) drain();
         end
         drain();
      end

      start <= 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      if (board.owed.size() != 0) $error("%0d responses never arrived", board.owed.size());
      $display("Sent %0d request words, checked %0d responses; list peaked at %0d entries.",
               issued, board.checked, board.peak);
      $display("Full-list rejections %0d, search hits %0d, field mismatches %0d.",
               board.full_rejects, board.search_hits, board.mismatches);
      if (board.mismatches == 0 && board.owed.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
